// ----- rtl/core/lpm_pkg.sv -----
package lpm_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int PORT_COUNT  = 16;

  localparam int ADDR_W = 32;
  localparam int LEN_W  = 6;
  localparam int PORT_W = 4;
  localparam int TTL_W  = 8;
  localparam int IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);
  localparam logic [TTL_W-1:0] TTL_MIN = TTL_W'(1);

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_ROUTE = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_ADDED        = 3'd0,
    ST_FULL         = 3'd1,
    ST_FORWARDED    = 3'd2,
    ST_DROP_TTL     = 3'd3,
    ST_DROP_NOROUTE = 3'd4
  } status_t;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_SEARCH = 1'b1
  } state_t;

  // Route write broadcast to the cell row
  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  idx;
    logic [ADDR_W-1:0] prefix;
    logic [LEN_W-1:0]  len;
    logic              has_hop;
    logic [ADDR_W-1:0] hop;
    logic [PORT_W-1:0] port;
  } lpm_wr_t;

  // Lookup request travelling down the cell row with its best match so far
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] dest;
    logic              found;
    logic [LEN_W-1:0]  best_len;
    logic [PORT_W-1:0] port;
    logic [ADDR_W-1:0] hop;
  } lpm_tok_t;

  function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
    len_mask = ~({ADDR_W{1'b1}} >> len);
  endfunction

  // Small table: port index reduced modulo PORT_COUNT
  function automatic logic [PORT_W-1:0] port_mod(input logic [PORT_W-1:0] p);
    logic [PORT_W-1:0] r;
    r = '0;
    for (int i = 0; i < (1 << PORT_W); i++) begin
      if (p == PORT_W'(i)) begin
        r = PORT_W'(i % PORT_COUNT);
      end
    end
    port_mod = r;
  endfunction

endpackage

// ----- rtl/core/lpm_chan_if.sv -----
interface lpm_req_if;
  logic                      valid;
  logic                      ready;
  lpm_pkg::op_t              operation;
  logic [lpm_pkg::ADDR_W-1:0] add_prefix;
  logic [lpm_pkg::LEN_W-1:0]  route_length;
  logic                      hop_present;
  logic [lpm_pkg::ADDR_W-1:0] hop_address;
  logic [lpm_pkg::PORT_W-1:0] route_port;
  logic [lpm_pkg::ADDR_W-1:0] dest_address;
  logic [lpm_pkg::TTL_W-1:0]  hops_left;

  modport source (
    output valid, operation, add_prefix, route_length, hop_present, hop_address,
           route_port, dest_address, hops_left,
    input  ready
  );
  modport sink (
    input  valid, operation, add_prefix, route_length, hop_present, hop_address,
           route_port, dest_address, hops_left,
    output ready
  );
endinterface

interface lpm_rsp_if;
  logic                      valid;
  logic                      ready;
  lpm_pkg::status_t          status;
  logic [lpm_pkg::PORT_W-1:0] out_port;
  logic [lpm_pkg::ADDR_W-1:0] out_hop;
  logic [lpm_pkg::TTL_W-1:0]  out_ttl;

  modport source (
    output valid, status, out_port, out_hop, out_ttl,
    input  ready
  );
  modport sink (
    input  valid, status, out_port, out_hop, out_ttl,
    output ready
  );
endinterface

// ----- rtl/core/lpm_cell.sv -----
module lpm_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [lpm_pkg::IDX_W-1:0] cell_idx,
  input  logic [lpm_pkg::CNT_W-1:0] entry_count,
  input  lpm_pkg::lpm_wr_t          wr,
  input  lpm_pkg::lpm_tok_t         tok_in,
  output lpm_pkg::lpm_tok_t         tok_out
);

  logic [lpm_pkg::ADDR_W-1:0] prefix_r;
  logic [lpm_pkg::LEN_W-1:0]  len_r;
  logic                       has_hop_r;
  logic [lpm_pkg::ADDR_W-1:0] hop_r;
  logic [lpm_pkg::PORT_W-1:0] port_r;

  lpm_pkg::lpm_tok_t tok_r;
  lpm_pkg::lpm_tok_t tok_nxt;

  logic in_use;
  logic hit;
  logic take;

  // Route storage, written once when this slot is allocated
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      prefix_r  <= wr.prefix;
      len_r     <= wr.len;
      has_hop_r <= wr.has_hop;
      hop_r     <= wr.hop;
      port_r    <= wr.port;
    end
  end

  always_comb begin
    in_use  = lpm_pkg::CNT_W'(cell_idx) < entry_count;
    hit     = in_use && ((tok_in.dest & lpm_pkg::len_mask(len_r)) == prefix_r);
    // strictly longer wins, so the earlier slot keeps ties
    take    = hit && (!tok_in.found || (len_r > tok_in.best_len));
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found    = 1'b1;
      tok_nxt.best_len = len_r;
      tok_nxt.port     = port_r;
      tok_nxt.hop      = has_hop_r ? hop_r : tok_in.dest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

// ----- rtl/core/longest_prefix_match_router.sv -----
// Response path: add and low-TTL items go through the pending stage and the output register;
//   a lookup walks the 64 cells of the row, one step per cell, then takes the same path.
// Throughput: adds and TTL drops 1 per cycle while the output is not stalled; a lookup
//   holds off all requests until it has walked the whole cell row, so one is in flight.
// Reset: synchronous, active low; clears the route count, the FSM and all valid flags.
//   Route storage is not cleared and needs no clearing pass.
module longest_prefix_match_router (
  input  logic       clk,
  input  logic       rst_n,
  lpm_req_if.sink    in_req,
  lpm_rsp_if.source  out_rsp
);

  // Control state
  lpm_pkg::state_t             state_r;
  lpm_pkg::state_t             state_nxt;
  logic [lpm_pkg::CNT_W-1:0]   count_r;
  logic [lpm_pkg::CNT_W-1:0]   count_nxt;

  // TTL of the lookup in flight
  logic [lpm_pkg::TTL_W-1:0]   ttl_r;

  // Pending response stage, ahead of the output register
  logic                        pend_valid_r;
  logic                        pend_valid_nxt;
  lpm_pkg::status_t            pend_status_r;
  lpm_pkg::status_t            pend_status_nxt;
  logic [lpm_pkg::PORT_W-1:0]  pend_port_r;
  logic [lpm_pkg::PORT_W-1:0]  pend_port_nxt;
  logic [lpm_pkg::ADDR_W-1:0]  pend_hop_r;
  logic [lpm_pkg::ADDR_W-1:0]  pend_hop_nxt;
  logic [lpm_pkg::TTL_W-1:0]   pend_ttl_r;
  logic [lpm_pkg::TTL_W-1:0]   pend_ttl_nxt;

  // Output register
  logic                        out_valid_r;
  lpm_pkg::status_t            out_status_r;
  logic [lpm_pkg::PORT_W-1:0]  out_port_r;
  logic [lpm_pkg::ADDR_W-1:0]  out_hop_r;
  logic [lpm_pkg::TTL_W-1:0]   out_ttl_r;

  logic accept;
  logic pend_move;
  logic is_add;
  logic ttl_low;
  logic full;
  logic start_search;
  logic ready_int;

  lpm_pkg::lpm_wr_t  wr;
  lpm_pkg::lpm_tok_t tok [0:lpm_pkg::TABLE_DEPTH];

  // Pending stage drains whenever the output register is free or being taken
  assign pend_move    = pend_valid_r && (!out_valid_r || out_rsp.ready);
  assign accept       = in_req.valid && ready_int;
  assign is_add       = (in_req.operation == lpm_pkg::OP_ADD);
  assign ttl_low      = (in_req.hops_left <= lpm_pkg::TTL_MIN);
  assign full         = (count_r == lpm_pkg::CNT_W'(lpm_pkg::TABLE_DEPTH));
  assign start_search = accept && !is_add && !ttl_low;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpm_pkg::S_IDLE: begin
        if (start_search) begin
          state_nxt = lpm_pkg::S_SEARCH;
        end
      end
      lpm_pkg::S_SEARCH: begin
        if (tok[lpm_pkg::TABLE_DEPTH].valid) begin
          state_nxt = lpm_pkg::S_IDLE;
        end
      end
      default: state_nxt = lpm_pkg::S_IDLE;
    endcase
  end

  // FSM outputs: take a request only when idle and the pending stage frees up
  always_comb begin
    ready_int = 1'b0;
    unique case (state_r)
      lpm_pkg::S_IDLE:   ready_int = !pend_valid_r || pend_move;
      lpm_pkg::S_SEARCH: ready_int = 1'b0;
      default:           ready_int = 1'b0;
    endcase
  end

  assign in_req.ready = ready_int;

  // Route write: append to the next free slot, saturate length, fold the port
  always_comb begin
    wr.en      = accept && is_add && !full;
    wr.idx     = count_r[lpm_pkg::IDX_W-1:0];
    wr.prefix  = in_req.add_prefix;
    wr.len     = (in_req.route_length > lpm_pkg::LEN_MAX) ? lpm_pkg::LEN_MAX
                                                          : in_req.route_length;
    wr.has_hop = in_req.hop_present;
    wr.hop     = in_req.hop_address;
    wr.port    = lpm_pkg::port_mod(in_req.route_port);
    count_nxt  = wr.en ? (count_r + lpm_pkg::CNT_W'(1)) : count_r;
  end

  // Inject the lookup request at the head of the cell row
  assign tok[0] = '{valid: start_search, dest: in_req.dest_address, default: '0};

  // Cell row: each cell owns one route slot and advances the request one step
  for (genvar g = 0; g < lpm_pkg::TABLE_DEPTH; g++) begin : g_cell
    lpm_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cell_idx    (lpm_pkg::IDX_W'(g)),
      .entry_count (count_r),
      .wr          (wr),
      .tok_in      (tok[g]),
      .tok_out     (tok[g+1])
    );
  end

  // Pending stage load: immediate responses on accept, lookup result at row end
  always_comb begin
    pend_valid_nxt  = pend_valid_r && !pend_move;
    pend_status_nxt = pend_status_r;
    pend_port_nxt   = pend_port_r;
    pend_hop_nxt    = pend_hop_r;
    pend_ttl_nxt    = pend_ttl_r;
    priority if (accept && (is_add || ttl_low)) begin
      pend_valid_nxt  = 1'b1;
      pend_port_nxt   = '0;
      pend_hop_nxt    = '0;
      pend_ttl_nxt    = '0;
      if (is_add) begin
        pend_status_nxt = full ? lpm_pkg::ST_FULL : lpm_pkg::ST_ADDED;
      end else begin
        pend_status_nxt = lpm_pkg::ST_DROP_TTL;
      end
    end else if (tok[lpm_pkg::TABLE_DEPTH].valid) begin
      pend_valid_nxt = 1'b1;
      if (tok[lpm_pkg::TABLE_DEPTH].found) begin
        pend_status_nxt = lpm_pkg::ST_FORWARDED;
        pend_port_nxt   = tok[lpm_pkg::TABLE_DEPTH].port;
        pend_hop_nxt    = tok[lpm_pkg::TABLE_DEPTH].hop;
        pend_ttl_nxt    = ttl_r - lpm_pkg::TTL_W'(1);
      end else begin
        pend_status_nxt = lpm_pkg::ST_DROP_NOROUTE;
        pend_port_nxt   = '0;
        pend_hop_nxt    = '0;
        pend_ttl_nxt    = '0;
      end
    end else begin
      // hold
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= lpm_pkg::S_IDLE;
      count_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      pend_valid_r <= pend_valid_nxt;
      if (pend_move) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (start_search) begin
      ttl_r <= in_req.hops_left;
    end
    pend_status_r <= pend_status_nxt;
    pend_port_r   <= pend_port_nxt;
    pend_hop_r    <= pend_hop_nxt;
    pend_ttl_r    <= pend_ttl_nxt;
    if (pend_move) begin
      out_status_r <= pend_status_r;
      out_port_r   <= pend_port_r;
      out_hop_r    <= pend_hop_r;
      out_ttl_r    <= pend_ttl_r;
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.status   = out_status_r;
  assign out_rsp.out_port = out_port_r;
  assign out_rsp.out_hop  = out_hop_r;
  assign out_rsp.out_ttl  = out_ttl_r;

endmodule

// ----- rtl/core/lpm_checker.sv -----
module lpm_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input lpm_pkg::status_t          status,
  input logic [lpm_pkg::PORT_W-1:0] out_port,
  input logic [lpm_pkg::ADDR_W-1:0] out_hop,
  input logic [lpm_pkg::TTL_W-1:0]  out_ttl
);

  // A stalled response stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(out_hop))
    else $error("response changed while stalled");

  // Only forwarded responses carry port, hop and TTL
  a_unused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status != lpm_pkg::ST_FORWARDED) |->
      (out_port == '0) && (out_hop == '0) && (out_ttl == '0))
    else $error("non-forwarded response with nonzero fields");

  // Forwarded datagrams had TTL of at least two, so the decremented TTL is nonzero
  a_fwd_ttl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == lpm_pkg::ST_FORWARDED) |-> (out_ttl != '0))
    else $error("forwarded with zero TTL");

  // Reset empties the output
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("response valid right after reset");

endmodule

bind longest_prefix_match_router lpm_checker u_lpm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_rsp.valid),
  .out_ready (out_rsp.ready),
  .status    (out_rsp.status),
  .out_port  (out_rsp.out_port),
  .out_hop   (out_rsp.out_hop),
  .out_ttl   (out_rsp.out_ttl)
);
